// ----- hdl/vfl_pkg.sv -----
// Shared widths, payload types and root-chain types for the vector length block.
package vfl_pkg;

  localparam int unsigned CompW     = 32;          // component width, 16.16
  localparam int unsigned SqW       = 2 * CompW;   // square and sum width, 32.32
  localparam int unsigned LenW      = 32;          // length width, 16.16
  localparam int unsigned RootSteps = SqW / 2;     // one radicand bit pair per cell
  localparam int unsigned RemW      = LenW + 3;    // remainder and doubled root width

  // Input word: three signed components
  typedef struct packed {
    logic signed [CompW-1:0] comp_x;
    logic signed [CompW-1:0] comp_y;
    logic signed [CompW-1:0] comp_z;
  } vfl_in_t;

  // Result word: length and wrap flag
  typedef struct packed {
    logic [LenW-1:0] length;
    logic            overflow;
  } vfl_out_t;

  // Payload handed from one root cell to the next
  typedef struct packed {
    logic            ovf;
    logic [SqW-1:0]  bits;
    logic [RemW-1:0] rem;
    logic [RemW-1:0] root;
  } vfl_root_t;

endpackage

// ----- hdl/vfl_square.sv -----
// Front end: component magnitudes, exact squares and the 64-bit sum of squares.
module vfl_square
  import vfl_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  vfl_in_t        in_i,
  output logic           valid_o,
  output logic [SqW-1:0] sum_o
);

  logic [2:0]       valid_q;
  logic [CompW-1:0] mag_x_q, mag_y_q, mag_z_q;
  logic [SqW-1:0]   sq_x_q, sq_y_q, sq_z_q;
  logic [SqW-1:0]   sum_q;

  // Magnitude of a two's complement value; the most negative code maps to 2^31
  function automatic logic [CompW-1:0] mag(input logic [CompW-1:0] v);
    mag = v[CompW-1] ? (~v + {{(CompW-1){1'b0}}, 1'b1}) : v;
  endfunction

  // Advance the stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  // Register magnitudes, then squares, then their sum
  always_ff @(posedge clk_i) begin
    mag_x_q <= mag(in_i.comp_x);
    mag_y_q <= mag(in_i.comp_y);
    mag_z_q <= mag(in_i.comp_z);
    sq_x_q  <= SqW'(mag_x_q) * SqW'(mag_x_q);
    sq_y_q  <= SqW'(mag_y_q) * SqW'(mag_y_q);
    sq_z_q  <= SqW'(mag_z_q) * SqW'(mag_z_q);
    sum_q   <= sq_x_q + sq_y_q + sq_z_q;
  end

  assign valid_o = valid_q[2];
  assign sum_o   = sum_q;

endmodule

// ----- hdl/vfl_root_cell.sv -----
// One restoring square root step: retire the top radicand bit pair.
module vfl_root_cell
  import vfl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  vfl_root_t data_i,
  output logic      valid_o,
  output vfl_root_t data_o
);

  logic      valid_q;
  vfl_root_t data_q;
  vfl_root_t data_d;
  logic [RemW-1:0] root_s;
  logic [RemW-1:0] rem_s;

  // Shift in the next bit pair and try the trial subtraction
  always_comb begin
    root_s      = {data_i.root[RemW-2:0], 1'b0};
    rem_s       = {data_i.rem[RemW-3:0], data_i.bits[SqW-1 -: 2]};
    data_d.ovf  = data_i.ovf;
    data_d.bits = {data_i.bits[SqW-3:0], 2'b00};
    if (root_s < rem_s) begin
      data_d.rem  = rem_s - (root_s | RemW'(1));
      data_d.root = root_s + RemW'(2);
    end else begin
      data_d.rem  = rem_s;
      data_d.root = root_s;
    end
  end

  // Hold the valid bit under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // Hand the word to the next cell
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hdl/vector3_fixed_length_top.sv -----
// Top level: square-and-sum front end, chain of root cells and result register.
//
// Fully pipelined: a new vector is taken on every cycle that start_i is high
// (busy_o stays low), and its result appears on res_o with done_o high for one
// cycle, registered through three front-end stages (magnitude, square, sum),
// one cell per root bit for 32 cells, and the output register. The receiver
// must take each result in the cycle it is shown. A sum of squares of 2^63
// or more sets overflow and forces length to zero.
module vector3_fixed_length_top
  import vfl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  output logic     busy_o,
  input  vfl_in_t  in_i,
  output logic     done_o,
  output vfl_out_t res_o
);

  logic           sum_valid;
  logic [SqW-1:0] sum;
  logic           chain_valid [RootSteps+1];
  vfl_root_t      chain_data  [RootSteps+1];
  logic           done_q;
  vfl_out_t       res_q;

  // Front end
  vfl_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .in_i    (in_i),
    .valid_o (sum_valid),
    .sum_o   (sum)
  );

  // Seed the chain with the sum; the top bit marks a wrapped sum
  assign chain_valid[0]     = sum_valid;
  assign chain_data[0].ovf  = sum[SqW-1];
  assign chain_data[0].bits = sum;
  assign chain_data[0].rem  = '0;
  assign chain_data[0].root = '0;

  // Chain of root cells
  for (genvar g = 0; g < RootSteps; g++) begin : g_cell
    vfl_root_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .data_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .data_o  (chain_data[g+1])
    );
  end

  // Strobe the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_valid[RootSteps];
    end
  end

  // Drop the doubled root to the length, zero on a wrapped sum
  always_ff @(posedge clk_i) begin
    res_q.overflow <= chain_data[RootSteps].ovf;
    res_q.length   <= chain_data[RootSteps].ovf ? '0 : chain_data[RootSteps].root[LenW:1];
  end

  assign busy_o = 1'b0;
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ----- tb/vector3_fixed_length_top_tb.sv -----
// Testbench for the vector length block: random and directed vectors, scoreboard check.
`timescale 1ns / 1ps

module vector3_fixed_length_top_tb
  import vfl_pkg::*;
;

  localparam int unsigned NumRandom  = 900;
  localparam int unsigned TailCycles = 40;     // pipeline depth plus margin
  localparam int unsigned StallLimit = 4000;   // cycles with no word moving

  // Expected lengths of accepted vectors, in order, and the length predictor
  class length_checker;
    vfl_out_t    lengths_q[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Floor square root by binary search on the root bits, top bit first
    static function logic [31:0] floor_root(logic [63:0] radicand);
      logic [31:0] r;
      logic [32:0] trial;
      logic [65:0] sq;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = {1'b0, r} | (33'd1 << b);
        sq = trial * trial;
        if (sq <= {2'b00, radicand}) r = trial[31:0];
      end
      return r;
    endfunction

    // Magnitude of one component, 2^31 for the most negative value
    static function logic [63:0] comp_mag(logic signed [CompW-1:0] c);
      logic [32:0] e;
      e = {c[CompW-1], c};
      if (c[CompW-1]) e = -e;
      return {31'b0, e};
    endfunction

    function vfl_out_t compute_length(vfl_in_t w);
      vfl_out_t    r;
      logic [63:0] ax, ay, az, total;
      ax = comp_mag(w.comp_x);
      ay = comp_mag(w.comp_y);
      az = comp_mag(w.comp_z);
      total = ax * ax + ay * ay + az * az;
      r.overflow = total[63];
      r.length   = (total[63] || total == 64'd0) ? '0 : floor_root(total);
      return r;
    endfunction

    function int pending();
      return lengths_q.size();
    endfunction

    function void note_input(vfl_in_t w);
      lengths_q.push_back(compute_length(w));
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(vfl_out_t got);
      vfl_out_t want;
      if (lengths_q.size() == 0) begin
        report($sformatf("unexpected result length=%h overflow=%b",
                         got.length, got.overflow));
      end else begin
        want = lengths_q.pop_front();
        if (got.length !== want.length)
          report($sformatf("length %h, expected %h", got.length, want.length));
        if (got.overflow !== want.overflow)
          report($sformatf("overflow %b, expected %b", got.overflow, want.overflow));
      end
    endtask
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start_i;
  logic     busy_o;
  vfl_in_t  in_i;
  logic     done_o;
  vfl_out_t res_o;

  length_checker board;
  int unsigned   quiet_cycles;

  vector3_fixed_length_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .in_i    (in_i),
    .done_o  (done_o),
    .res_o   (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Note accepted words, check results, and watch for a stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) board.note_input(in_i);
      if (done_o) board.check_result(res_o);
    end
    if (rst_ni && ((start_i && !busy_o) || done_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("vector3_fixed_length_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Build a component from a magnitude and a sign, clamping at -2^31
  function automatic logic [31:0] signed_comp(logic [32:0] mag, bit neg);
    if (mag >= 33'h0_8000_0000) return 32'h8000_0000;
    return neg ? -mag[31:0] : mag[31:0];
  endfunction

  function automatic logic [31:0] short_comp();
    return signed_comp({1'b0, $urandom >> $urandom_range(0, 31)},
                       1'($urandom_range(0, 1)));
  endfunction

  // Random vector: full range, short magnitudes, or near the wrap boundary
  function automatic vfl_in_t make_vector();
    vfl_in_t     w;
    logic [63:0] mx, my, rest;
    logic [32:0] mz;
    case ($urandom_range(0, 3))
      0: begin
        w.comp_x = $urandom;
        w.comp_y = $urandom;
        w.comp_z = $urandom;
      end
      1, 2: begin
        w.comp_x = short_comp();
        w.comp_y = short_comp();
        w.comp_z = short_comp();
      end
      default: begin
        mx = 64'($urandom_range(32'h5000_0000));
        my = 64'($urandom_range(32'h5000_0000));
        rest = 64'h7FFF_FFFF_FFFF_FFFF - mx * mx - my * my;
        mz = {1'b0, length_checker::floor_root(rest)} + 33'($urandom_range(0, 4));
        if (mz >= 33'd2) mz = mz - 33'd2;
        w.comp_x = signed_comp(mx[32:0], 1'($urandom_range(0, 1)));
        w.comp_y = signed_comp(my[32:0], 1'($urandom_range(0, 1)));
        w.comp_z = signed_comp(mz, 1'($urandom_range(0, 1)));
      end
    endcase
    return w;
  endfunction

  // Present one word and hold it until the block takes it
  task automatic send_word(input vfl_in_t w);
    start_i <= 1'b1;
    in_i    <= w;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Drop start with junk on the data lines
  task automatic hold_off(input int unsigned n);
    start_i <= 1'b0;
    in_i    <= {$urandom, $urandom, $urandom};
    repeat (n) @(posedge clk_i);
  endtask

  // Drop start and wait until every expected result has come back
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Idle after about 15 percent of words, mostly briefly, now and then longer
  task automatic maybe_idle();
    if ($urandom_range(0, 99) < 15)
      hold_off(($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3));
  endtask

  initial begin
    vfl_in_t directed[$];
    board = new();
    quiet_cycles = 0;
    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    in_i    <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero vector, unit steps, exact roots, extremes and the wrap boundary
    directed.push_back('{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000});
    directed.push_back('{32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000});
    directed.push_back('{-32'sh1, -32'sh1, -32'sh1});
    directed.push_back('{32'sh0003_0000, 32'sh0004_0000, 32'sh0000_0000});
    directed.push_back('{32'sh0000_0000, -32'sh0003_0000, 32'sh0004_0000});
    directed.push_back('{32'sh0001_0000, 32'sh0000_0000, 32'sh0000_0000});
    directed.push_back('{32'sh8000_0000, 32'sh0000_0000, 32'sh0000_0000});
    directed.push_back('{32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0000});
    directed.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000});
    directed.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0000});
    directed.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0000_0000});
    directed.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF});
    directed.push_back('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000});
    directed.push_back('{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555});
    directed.push_back('{32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA});
    directed.push_back('{32'sh0000_FFFF, 32'shFFFF_0000, 32'sh0000_8000});
    directed.push_back('{32'sh6ED9_EBA1, 32'sh0000_0000, 32'sh0000_0000});
    directed.push_back('{32'sh4000_0000, 32'sh4000_0000, 32'sh4000_0000});
    foreach (directed[i]) begin
      send_word(directed[i]);
      maybe_idle();
    end
    drain();

    // Random vectors, with a stretch of back-to-back words and periodic drains
    for (int unsigned n = 0; n < NumRandom; n++) begin
      send_word(make_vector());
      if (n % 250 == 249) drain();
      else if (n < 400 || n >= 550) maybe_idle();
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("vector3_fixed_length_top regression: pass");
    end else begin
      $display("vector3_fixed_length_top regression: fail");
    end
    $finish;
  end

endmodule
